[sv/ps2_keyboard_controller_unit_defines.svh]
// Assertion macros used by the back end of the keyboard controller RTL.
`ifndef PS2_KEYBOARD_CONTROLLER_UNIT_DEFINES_SVH
`define PS2_KEYBOARD_CONTROLLER_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PS2KC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PS2KC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ps2kc_pkg.sv]
// Types, constants and helper functions of the PS/2 keyboard controller.
`default_nettype none

package ps2kc_pkg;

	// Item kinds on the input channel
	localparam logic [2:0] KIND_STATUS_RD = 3'd0;
	localparam logic [2:0] KIND_DATA_RD   = 3'd1;
	localparam logic [2:0] KIND_CMD_WR    = 3'd2;
	localparam logic [2:0] KIND_DATA_WR   = 3'd3;
	localparam logic [2:0] KIND_KBD_LVL   = 3'd4;
	localparam logic [2:0] KIND_AUX_LVL   = 3'd5;

	// Controller command bytes
	localparam logic [7:0] KBC_READ_MODE  = 8'h20;
	localparam logic [7:0] KBC_WRITE_MODE = 8'h60;
	localparam logic [7:0] KBC_AUX_DIS    = 8'hA7;
	localparam logic [7:0] KBC_AUX_EN     = 8'hA8;
	localparam logic [7:0] KBC_AUX_TEST   = 8'hA9;
	localparam logic [7:0] KBC_SELF_TEST  = 8'hAA;
	localparam logic [7:0] KBC_KBD_TEST   = 8'hAB;
	localparam logic [7:0] KBC_KBD_DIS    = 8'hAD;
	localparam logic [7:0] KBC_KBD_EN     = 8'hAE;
	localparam logic [7:0] KBC_READ_IN    = 8'hC0;
	localparam logic [7:0] KBC_READ_OUT   = 8'hD0;
	localparam logic [7:0] KBC_WRITE_OUT  = 8'hD1;
	localparam logic [7:0] KBC_WRITE_KBDQ = 8'hD2;
	localparam logic [7:0] KBC_WRITE_AUXQ = 8'hD3;
	localparam logic [7:0] KBC_WRITE_AUX  = 8'hD4;
	localparam logic [7:0] KBC_A20_OFF    = 8'hDD;
	localparam logic [7:0] KBC_A20_ON     = 8'hDF;
	localparam logic [7:0] KBC_PULSE_RST  = 8'hFE;
	localparam logic [7:0] KBC_PULSE_NOP  = 8'hFF;
	localparam logic [3:0] KBC_PULSE_HI   = 4'hF;

	// Reply bytes
	localparam logic [7:0] REPLY_SELF_OK = 8'h55;
	localparam logic [7:0] REPLY_IN_PORT = 8'h80;
	localparam logic [7:0] REPLY_ZERO    = 8'h00;

	// Reset values
	localparam logic [7:0] MODE_RESET    = 8'h03;
	localparam logic [7:0] STATUS_RESET  = 8'h18;
	localparam logic [7:0] OUTPORT_RESET = 8'h03;

	// Queue and forward targets
	localparam logic [1:0] TGT_NONE = 2'd0;
	localparam logic [1:0] TGT_KBD  = 2'd1;
	localparam logic [1:0] TGT_AUX  = 2'd2;

	// Pending bits: keyboard in bit 0, aux in bit 1
	localparam logic [1:0] PEND_NONE     = 2'b00;
	localparam logic [1:0] PEND_AUX_ONLY = 2'b10;

	// Queue between front and back
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		OP_NONE,
		OP_STATUS_RD,
		OP_DATA_RD,
		OP_CMD,
		OP_DATA_WR,
		OP_KBD_LVL,
		OP_AUX_LVL
	} op_t;

	typedef enum logic [4:0] {
		CC_READ_MODE,
		CC_AW_MODE,
		CC_AW_OUT,
		CC_AW_KBDQ,
		CC_AW_AUXQ,
		CC_AW_MOUSE,
		CC_AUX_DIS,
		CC_AUX_EN,
		CC_PUSH_ZERO,
		CC_SELF_TEST,
		CC_KBD_DIS,
		CC_KBD_EN,
		CC_PUSH_IN,
		CC_READ_OUT,
		CC_A20_ON,
		CC_A20_OFF,
		CC_RESET,
		CC_NOP,
		CC_UNSUP
	} cc_t;

	typedef enum logic [2:0] {
		AW_NONE,
		AW_MODE,
		AW_OUT,
		AW_KBDQ,
		AW_AUXQ,
		AW_MOUSE
	} aw_t;

	typedef struct packed {
		op_t        op;
		cc_t        cc;
		logic [7:0] value;
		logic       level;
	} qentry_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic [1:0] pop_source;
		logic [1:0] push_target;
		logic [7:0] push_byte;
		logic [1:0] forward_target;
		logic [7:0] forward_byte;
		logic       kbd_irq;
		logic       aux_irq;
		logic       translate;
		logic       reset_request;
		logic       a20_gate;
		logic       unsupported;
	} result_t;

	typedef struct packed {
		logic [7:0] status;
		logic [7:0] outport;
		logic       kbd_line;
		logic       aux_line;
	} lines_t;

	// Rebuild buffer-full bits and IRQ lines from the pending bits
	function automatic lines_t recompute(input logic [1:0] pend, input logic [7:0] mode,
			input logic [7:0] status, input logic [7:0] outport);
		lines_t r;
		r.status   = status & 8'hDE;
		r.outport  = outport & 8'hCF;
		r.kbd_line = 1'b0;
		r.aux_line = 1'b0;
		if (pend != PEND_NONE) begin
			r.status[0]  = 1'b1;
			r.outport[4] = 1'b1;
			if (pend == PEND_AUX_ONLY) begin
				r.status[5]  = 1'b1;
				r.outport[5] = 1'b1;
				r.aux_line   = mode[1];
			end else begin
				r.kbd_line = mode[0] & ~mode[4];
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[sv/ps2kc_front.sv]
// Front end: classifies input items and decodes controller command bytes.
`default_nettype none

module ps2kc_front (
	input  wire logic [2:0]        command,
	input  wire logic [7:0]        value,
	input  wire logic              level,
	output ps2kc_pkg::qentry_t     entry
);
	import ps2kc_pkg::*;

	logic [7:0] cbyte;
	cc_t        cc;

	// Fold pulse commands into reset or no-op
	always_comb begin
		cbyte = value;
		if (value[7:4] == KBC_PULSE_HI) begin
			cbyte = value[0] ? KBC_PULSE_NOP : KBC_PULSE_RST;
		end
	end

	always_comb begin
		unique case (cbyte)
			KBC_READ_MODE:  cc = CC_READ_MODE;
			KBC_WRITE_MODE: cc = CC_AW_MODE;
			KBC_WRITE_OUT:  cc = CC_AW_OUT;
			KBC_WRITE_KBDQ: cc = CC_AW_KBDQ;
			KBC_WRITE_AUXQ: cc = CC_AW_AUXQ;
			KBC_WRITE_AUX:  cc = CC_AW_MOUSE;
			KBC_AUX_DIS:    cc = CC_AUX_DIS;
			KBC_AUX_EN:     cc = CC_AUX_EN;
			KBC_AUX_TEST,
			KBC_KBD_TEST:   cc = CC_PUSH_ZERO;
			KBC_SELF_TEST:  cc = CC_SELF_TEST;
			KBC_KBD_DIS:    cc = CC_KBD_DIS;
			KBC_KBD_EN:     cc = CC_KBD_EN;
			KBC_READ_IN:    cc = CC_PUSH_IN;
			KBC_READ_OUT:   cc = CC_READ_OUT;
			KBC_A20_ON:     cc = CC_A20_ON;
			KBC_A20_OFF:    cc = CC_A20_OFF;
			KBC_PULSE_RST:  cc = CC_RESET;
			KBC_PULSE_NOP:  cc = CC_NOP;
			default:        cc = CC_UNSUP;
		endcase
	end

	always_comb begin
		entry.cc    = cc;
		entry.value = value;
		entry.level = level;
		unique case (command)
			KIND_STATUS_RD: entry.op = OP_STATUS_RD;
			KIND_DATA_RD:   entry.op = OP_DATA_RD;
			KIND_CMD_WR:    entry.op = OP_CMD;
			KIND_DATA_WR:   entry.op = OP_DATA_WR;
			KIND_KBD_LVL:   entry.op = OP_KBD_LVL;
			KIND_AUX_LVL:   entry.op = OP_AUX_LVL;
			default:        entry.op = OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

[sv/ps2kc_queue.sv]
// Short queue of decoded items between the front and back ends.
`default_nettype none

module ps2kc_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire ps2kc_pkg::qentry_t  push_entry,
	output logic                     full,
	input  wire logic                pop,
	output ps2kc_pkg::qentry_t       pop_entry,
	output logic                     empty
);
	import ps2kc_pkg::*;

	qentry_t            slot_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[sv/ps2kc_back.sv]
// Back end: carries out decoded items on the controller state, registers results.
`default_nettype none
`include "ps2_keyboard_controller_unit_defines.svh"

module ps2kc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ps2kc_pkg::qentry_t entry,
	input  wire logic               empty,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output ps2kc_pkg::result_t      result
);
	import ps2kc_pkg::*;

	logic [7:0] mode_q, status_q, outport_q;
	logic [1:0] pending_q;
	aw_t        awaited_q;
	logic       kbd_line_q, aux_line_q;
	logic       out_valid_q;
	result_t    result_q;

	logic [7:0] mode_n, status_n, outport_n;
	logic [1:0] pending_n;
	aw_t        awaited_n;
	logic       kbd_line_n, aux_line_n;
	logic       do_rec;
	lines_t     rec;
	result_t    res;

	// Take an item whenever the output register is free or being emptied
	assign pop       = !empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign result    = result_q;

	always_comb begin
		mode_n    = mode_q;
		status_n  = status_q;
		outport_n = outport_q;
		pending_n = pending_q;
		awaited_n = awaited_q;
		do_rec    = 1'b0;
		res       = '0;
		unique case (entry.op)
			OP_STATUS_RD: res.read_byte = status_q;
			OP_DATA_RD:   res.pop_source = (pending_q == PEND_AUX_ONLY) ? TGT_AUX : TGT_KBD;
			OP_CMD: begin
				unique case (entry.cc)
					CC_READ_MODE: begin
						res.push_target = TGT_KBD;
						res.push_byte   = mode_q;
					end
					CC_AW_MODE:   awaited_n = AW_MODE;
					CC_AW_OUT:    awaited_n = AW_OUT;
					CC_AW_KBDQ:   awaited_n = AW_KBDQ;
					CC_AW_AUXQ:   awaited_n = AW_AUXQ;
					CC_AW_MOUSE:  awaited_n = AW_MOUSE;
					CC_AUX_DIS:   mode_n[5] = 1'b1;
					CC_AUX_EN:    mode_n[5] = 1'b0;
					CC_PUSH_ZERO: begin
						res.push_target = TGT_KBD;
						res.push_byte   = REPLY_ZERO;
					end
					CC_SELF_TEST: begin
						status_n[2]     = 1'b1;
						res.push_target = TGT_KBD;
						res.push_byte   = REPLY_SELF_OK;
					end
					CC_KBD_DIS: begin
						mode_n[4] = 1'b1;
						do_rec    = 1'b1;
					end
					CC_KBD_EN: begin
						mode_n[4] = 1'b0;
						do_rec    = 1'b1;
					end
					CC_PUSH_IN: begin
						res.push_target = TGT_KBD;
						res.push_byte   = REPLY_IN_PORT;
					end
					CC_READ_OUT: begin
						res.push_target = TGT_KBD;
						res.push_byte   = outport_q;
					end
					CC_A20_ON:    outport_n[1] = 1'b1;
					CC_A20_OFF:   outport_n[1] = 1'b0;
					CC_RESET:     res.reset_request = 1'b1;
					CC_NOP:       ;
					default:      res.unsupported = 1'b1;
				endcase
			end
			OP_DATA_WR: begin
				awaited_n = AW_NONE;
				unique case (awaited_q)
					AW_NONE: begin
						res.forward_target = TGT_KBD;
						res.forward_byte   = entry.value;
					end
					AW_MODE: begin
						mode_n = entry.value;
						do_rec = 1'b1;
					end
					AW_KBDQ: begin
						res.push_target = TGT_KBD;
						res.push_byte   = entry.value;
					end
					AW_AUXQ: begin
						res.push_target = TGT_AUX;
						res.push_byte   = entry.value;
					end
					AW_OUT: begin
						outport_n         = entry.value;
						res.reset_request = ~entry.value[0];
					end
					AW_MOUSE: begin
						res.forward_target = TGT_AUX;
						res.forward_byte   = entry.value;
					end
					default: ;
				endcase
			end
			OP_KBD_LVL: begin
				pending_n[0] = entry.level;
				do_rec       = 1'b1;
			end
			OP_AUX_LVL: begin
				pending_n[1] = entry.level;
				do_rec       = 1'b1;
			end
			default: ;
		endcase

		rec        = recompute(pending_n, mode_n, status_n, outport_n);
		kbd_line_n = kbd_line_q;
		aux_line_n = aux_line_q;
		if (do_rec) begin
			status_n   = rec.status;
			outport_n  = rec.outport;
			kbd_line_n = rec.kbd_line;
			aux_line_n = rec.aux_line;
		end

		res.kbd_irq   = kbd_line_n;
		res.aux_irq   = aux_line_n;
		res.translate = mode_n[6];
		res.a20_gate  = outport_n[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_RESET;
			status_q    <= STATUS_RESET;
			outport_q   <= OUTPORT_RESET;
			pending_q   <= PEND_NONE;
			awaited_q   <= AW_NONE;
			kbd_line_q  <= 1'b0;
			aux_line_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q     <= mode_n;
				status_q   <= status_n;
				outport_q  <= outport_n;
				pending_q  <= pending_n;
				awaited_q  <= awaited_n;
				kbd_line_q <= kbd_line_n;
				aux_line_q <= aux_line_n;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= res;
		end
	end

	`PS2KC_ASSERT_NOW(a_irq_excl, 1'b1, !(kbd_line_q && aux_line_q), "both IRQ lines high")
	`PS2KC_ASSERT_NOW(a_aux_pend, aux_line_q, pending_q == PEND_AUX_ONLY, "aux IRQ without aux-only data")
	`PS2KC_ASSERT_NEXT(a_aw_clear, pop && (entry.op == OP_DATA_WR), awaited_q == AW_NONE, "awaited command kept after data write")
	`PS2KC_ASSERT_NEXT(a_obf_track, pop && ((entry.op == OP_KBD_LVL) || (entry.op == OP_AUX_LVL)), status_q[0] == (pending_q != PEND_NONE), "buffer-full bit out of step")

endmodule

`default_nettype wire

[sv/ps2_keyboard_controller_unit.sv]
// Top level of the PS/2 keyboard controller of the 8042 kind.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one bus access or level event per
//   item: command selects status read, data read, command write, data write,
//   keyboard level or aux level; value and level give its operands.
//   Output channel (out_valid/out_ready) returns exactly one result per item, in
//   order: status byte, queue pop, host queue push, device forward, IRQ lines,
//   translate, reset request, A20 gate and the unsupported-command flag.
//   An accepted item is written into the queue, then executed into the output register
//   once it heads the queue and the output register is free or being emptied.
//   Throughput: one item per cycle while the receiver takes results; the state
//   update in the back end is a single decode-and-update step on byte registers.
//   Reset (arst_n low): mode 0x03, status 0x18, output port 0x03, nothing pending,
//   no command awaiting data, both IRQ lines low; queue and output register empty.
//   When the receiver stalls the result is held; the two-entry queue keeps taking
//   items until it fills, then in_ready drops.
`default_nettype none

module ps2_keyboard_controller_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] command,
	input  wire logic [7:0] value,
	input  wire logic       level,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      read_byte,
	output logic [1:0]      pop_source,
	output logic [1:0]      push_target,
	output logic [7:0]      push_byte,
	output logic [1:0]      forward_target,
	output logic [7:0]      forward_byte,
	output logic            kbd_irq,
	output logic            aux_irq,
	output logic            translate,
	output logic            reset_request,
	output logic            a20_gate,
	output logic            unsupported
);
	import ps2kc_pkg::*;

	qentry_t in_entry;
	qentry_t q_entry;
	logic    q_full, q_empty, q_pop;
	result_t res;

	assign in_ready = !q_full;

	ps2kc_front u_front (
		.command (command),
		.value   (value),
		.level   (level),
		.entry   (in_entry)
	);

	ps2kc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_valid && !q_full),
		.push_entry (in_entry),
		.full       (q_full),
		.pop        (q_pop),
		.pop_entry  (q_entry),
		.empty      (q_empty)
	);

	ps2kc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.entry     (q_entry),
		.empty     (q_empty),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (res)
	);

	assign read_byte      = res.read_byte;
	assign pop_source     = res.pop_source;
	assign push_target    = res.push_target;
	assign push_byte      = res.push_byte;
	assign forward_target = res.forward_target;
	assign forward_byte   = res.forward_byte;
	assign kbd_irq        = res.kbd_irq;
	assign aux_irq        = res.aux_irq;
	assign translate      = res.translate;
	assign reset_request  = res.reset_request;
	assign a20_gate       = res.a20_gate;
	assign unsupported    = res.unsupported;

endmodule

`default_nettype wire
